// ===== rtl/core/dpgs_pkg.sv =====
package dpgs_pkg;

   // Request payload: one point and its gradient.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic               last_point;
   } req_type;

   // Response payload: the updated point.
   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic               was_clamped;
      logic               last_out;
   } rsp_type;

   // Per-point data that rides along the square root and divider chains.
   typedef struct packed {
      logic signed [31:0] mx;
      logic signed [31:0] my;
      logic               clamped;
      logic               last;
      logic               neg_x;
      logic               neg_y;
   } tag_type;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_STEP     = 2'd0;
   localparam logic [1:0] CSR_CENTER_X = 2'd1;
   localparam logic [1:0] CSR_CENTER_Y = 2'd2;
   localparam logic [1:0] CSR_RADIUS   = 2'd3;

   localparam int ROOT_BITS = 32;
   localparam int QUO_BITS  = 31;

   // Saturate a wide signed value to 32 signed bits.
   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -65'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/dpgs_sqrt_cell.sv =====
module dpgs_sqrt_cell #(
   parameter int K = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_i,
   input  dpgs_pkg::tag_type tag_i,
   input  logic [61:0]       mulx_i,
   input  logic [61:0]       muly_i,
   input  logic [63:0]       rem_i,
   input  logic [63:0]       root_i,
   output logic              valid_o,
   output dpgs_pkg::tag_type tag_o,
   output logic [61:0]       mulx_o,
   output logic [61:0]       muly_o,
   output logic [63:0]       rem_o,
   output logic [63:0]       root_o
);
   import dpgs_pkg::*;

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

   logic        valid_ff;
   tag_type     tag_ff;
   logic [61:0] mulx_ff, muly_ff;
   logic [63:0] rem_ff, rem_in, root_ff, root_in;
   logic [63:0] trial;

   // One digit of the bitwise square root recurrence.
   always_comb begin
      trial = root_i + BIT;
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         root_in = (root_i >> 1) + BIT;
      end else begin
         rem_in  = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff  <= tag_i;
         mulx_ff <= mulx_i;
         muly_ff <= muly_i;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign valid_o = valid_ff;
   assign tag_o   = tag_ff;
   assign mulx_o  = mulx_ff;
   assign muly_o  = muly_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;

endmodule

// ===== rtl/core/dpgs_div_cell.sv =====
module dpgs_div_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_i,
   input  dpgs_pkg::tag_type tag_i,
   input  logic [31:0]       den_i,
   input  logic [30:0]       numx_i,
   input  logic [30:0]       numy_i,
   input  logic [31:0]       remx_i,
   input  logic [31:0]       remy_i,
   input  logic [30:0]       qx_i,
   input  logic [30:0]       qy_i,
   output logic              valid_o,
   output dpgs_pkg::tag_type tag_o,
   output logic [31:0]       den_o,
   output logic [30:0]       numx_o,
   output logic [30:0]       numy_o,
   output logic [31:0]       remx_o,
   output logic [31:0]       remy_o,
   output logic [30:0]       qx_o,
   output logic [30:0]       qy_o
);
   import dpgs_pkg::*;

   logic        valid_ff;
   tag_type     tag_ff;
   logic [31:0] den_ff;
   logic [30:0] numx_ff, numy_ff, qx_ff, qy_ff, qx_in, qy_in;
   logic [31:0] remx_ff, remy_ff, remx_in, remy_in;
   logic [32:0] tx, ty;

   // One restoring step for each coordinate; the shared divisor is the norm.
   always_comb begin
      tx = {remx_i, numx_i[30 - STEP]};
      ty = {remy_i, numy_i[30 - STEP]};
      if (tx >= {1'b0, den_i}) begin
         remx_in = 32'(tx - {1'b0, den_i});
         qx_in   = {qx_i[29:0], 1'b1};
      end else begin
         remx_in = tx[31:0];
         qx_in   = {qx_i[29:0], 1'b0};
      end
      if (ty >= {1'b0, den_i}) begin
         remy_in = 32'(ty - {1'b0, den_i});
         qy_in   = {qy_i[29:0], 1'b1};
      end else begin
         remy_in = ty[31:0];
         qy_in   = {qy_i[29:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff  <= tag_i;
         den_ff  <= den_i;
         numx_ff <= numx_i;
         numy_ff <= numy_i;
         remx_ff <= remx_in;
         remy_ff <= remy_in;
         qx_ff   <= qx_in;
         qy_ff   <= qy_in;
      end
   end

   assign valid_o = valid_ff;
   assign tag_o   = tag_ff;
   assign den_o   = den_ff;
   assign numx_o  = numx_ff;
   assign numy_o  = numy_ff;
   assign remx_o  = remx_ff;
   assign remy_o  = remy_ff;
   assign qx_o    = qx_ff;
   assign qy_o    = qy_ff;

endmodule

// ===== rtl/core/disk_projected_gradient_step_unit.sv =====
// A request passes stages 1 to 5, the square root cells, the numerator register
// and the divider cells on its way to the final stage and the response register.
// Throughput: one request per cycle; the whole pipeline advances together and
// halts only while the response register is full and stalled.
// The square root takes 32 cells and the divider 31 cells, one bit per cell.
// Reset (synchronous, active high) empties the pipeline and loads the
// registers with step 1.0, center at the origin and radius 1.0.
module disk_projected_gradient_step_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dpgs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpgs_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_idx,
   input  logic [31:0]       csr_wdata
);
   import dpgs_pkg::*;

   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic en;

   // Configuration registers.
   logic signed [31:0] step_ff, cx_ff, cy_ff;
   logic [30:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 32'sd65536;
         cx_ff   <= 32'sd0;
         cy_ff   <= 32'sd0;
         rad_ff  <= 31'd65536;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_STEP:     step_ff <= csr_wdata;
            CSR_CENTER_X: cx_ff   <= csr_wdata;
            CSR_CENTER_Y: cy_ff   <= csr_wdata;
            CSR_RADIUS:   rad_ff  <= csr_wdata[30:0];
            default:      ;
         endcase
      end
   end

   // The pipeline moves whenever the response register can take a new value.
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // Stage 1: gradient times step factor.
   logic               v1_ff;
   logic signed [63:0] px_ff, py_ff;
   logic signed [31:0] pos1x_ff, pos1y_ff;
   logic               last1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= req_data.grad_x * step_ff;
         py_ff    <= req_data.grad_y * step_ff;
         pos1x_ff <= req_data.pos_x;
         pos1y_ff <= req_data.pos_y;
         last1_ff <= req_data.last_point;
      end
   end

   // Stage 2: round half up, add to the position and saturate.
   logic               v2_ff, last2_ff;
   logic signed [31:0] mx_ff, my_ff, mx_in, my_in;
   logic signed [63:0] dlx, dly;

   always_comb begin
      dlx   = (px_ff + HALF) >>> FRAC_BITS;
      dly   = (py_ff + HALF) >>> FRAC_BITS;
      mx_in = sat32(65'(pos1x_ff) + 65'(dlx));
      my_in = sat32(65'(pos1y_ff) + 65'(dly));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         last2_ff <= last1_ff;
      end
   end

   // Stage 3: offset from the center, magnitudes and range shift.
   logic               v3_ff;
   tag_type            tag3_ff, tag3_in;
   logic [30:0]        ux_ff, uy_ff, ux_in, uy_in;
   logic               big_ff, big_in;
   logic signed [32:0] dx, dy;
   logic [32:0]        ax, ay;

   always_comb begin
      dx = 33'(mx_ff) - 33'(cx_ff);
      dy = 33'(my_ff) - 33'(cy_ff);
      ax = dx[32] ? 33'(-dx) : 33'(dx);
      ay = dy[32] ? 33'(-dy) : 33'(dy);
      big_in = ax[32] | ax[31] | ay[32] | ay[31];
      if (ax[32] || ay[32]) begin
         ux_in = ax[32:2];
         uy_in = ay[32:2];
      end else if (ax[31] || ay[31]) begin
         ux_in = ax[31:1];
         uy_in = ay[31:1];
      end else begin
         ux_in = ax[30:0];
         uy_in = ay[30:0];
      end
      tag3_in.mx      = mx_ff;
      tag3_in.my      = my_ff;
      tag3_in.clamped = 1'b0;
      tag3_in.last    = last2_ff;
      tag3_in.neg_x   = dx[32];
      tag3_in.neg_y   = dy[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag3_ff <= tag3_in;
         ux_ff   <= ux_in;
         uy_ff   <= uy_in;
         big_ff  <= big_in;
      end
   end

   // Stage 4: squares and products with the radius.
   logic        v4_ff, big4_ff;
   tag_type     tag4_ff;
   logic [61:0] sqx_ff, sqy_ff, rr_ff, mulx_ff, muly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag4_ff <= tag3_ff;
         big4_ff <= big_ff;
         sqx_ff  <= 62'(ux_ff) * 62'(ux_ff);
         sqy_ff  <= 62'(uy_ff) * 62'(uy_ff);
         rr_ff   <= 62'(rad_ff) * 62'(rad_ff);
         mulx_ff <= 62'(ux_ff) * 62'(rad_ff);
         muly_ff <= 62'(uy_ff) * 62'(rad_ff);
      end
   end

   // Stage 5: squared norm and the outside test.
   logic        v5_ff;
   tag_type     tag5_ff, tag5_in;
   logic [63:0] sum5_ff, sum5_in;
   logic [61:0] mulx5_ff, muly5_ff;

   always_comb begin
      sum5_in         = 64'(sqx_ff) + 64'(sqy_ff);
      tag5_in         = tag4_ff;
      tag5_in.clamped = big4_ff || (sum5_in > 64'(rr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag5_ff  <= tag5_in;
         sum5_ff  <= sum5_in;
         mulx5_ff <= mulx_ff;
         muly5_ff <= muly_ff;
      end
   end

   // Square root chain, one result bit per cell.
   logic        sv   [ROOT_BITS + 1];
   tag_type     stag [ROOT_BITS + 1];
   logic [61:0] smx  [ROOT_BITS + 1];
   logic [61:0] smy  [ROOT_BITS + 1];
   logic [63:0] srem [ROOT_BITS + 1];
   logic [63:0] sroot[ROOT_BITS + 1];

   assign sv[0]    = v5_ff;
   assign stag[0]  = tag5_ff;
   assign smx[0]   = mulx5_ff;
   assign smy[0]   = muly5_ff;
   assign srem[0]  = sum5_ff;
   assign sroot[0] = 64'd0;

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      dpgs_sqrt_cell #(.K(k)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .valid_i(sv[k]),
         .tag_i  (stag[k]),
         .mulx_i (smx[k]),
         .muly_i (smy[k]),
         .rem_i  (srem[k]),
         .root_i (sroot[k]),
         .valid_o(sv[k + 1]),
         .tag_o  (stag[k + 1]),
         .mulx_o (smx[k + 1]),
         .muly_o (smy[k + 1]),
         .rem_o  (srem[k + 1]),
         .root_o (sroot[k + 1])
      );
   end

   // Numerator with rounding term; the divider starts from its upper bits.
   logic        vn_ff;
   tag_type     tagn_ff;
   logic [31:0] nrm_ff, nrm_in;
   logic [62:0] numx_ff, numy_ff;

   assign nrm_in = sroot[ROOT_BITS][31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (en) begin
         vn_ff <= sv[ROOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tagn_ff <= stag[ROOT_BITS];
         nrm_ff  <= nrm_in;
         numx_ff <= 63'(smx[ROOT_BITS]) + 63'(nrm_in >> 1);
         numy_ff <= 63'(smy[ROOT_BITS]) + 63'(nrm_in >> 1);
      end
   end

   // Divider chain, one quotient bit per cell.
   logic        dv   [QUO_BITS + 1];
   tag_type     dtag [QUO_BITS + 1];
   logic [31:0] dden [QUO_BITS + 1];
   logic [30:0] dnx  [QUO_BITS + 1];
   logic [30:0] dny  [QUO_BITS + 1];
   logic [31:0] drx  [QUO_BITS + 1];
   logic [31:0] dry  [QUO_BITS + 1];
   logic [30:0] dqx  [QUO_BITS + 1];
   logic [30:0] dqy  [QUO_BITS + 1];

   assign dv[0]   = vn_ff;
   assign dtag[0] = tagn_ff;
   assign dden[0] = nrm_ff;
   assign dnx[0]  = numx_ff[30:0];
   assign dny[0]  = numy_ff[30:0];
   assign drx[0]  = numx_ff[62:31];
   assign dry[0]  = numy_ff[62:31];
   assign dqx[0]  = 31'd0;
   assign dqy[0]  = 31'd0;

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_div
      dpgs_div_cell #(.STEP(s)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .valid_i(dv[s]),
         .tag_i  (dtag[s]),
         .den_i  (dden[s]),
         .numx_i (dnx[s]),
         .numy_i (dny[s]),
         .remx_i (drx[s]),
         .remy_i (dry[s]),
         .qx_i   (dqx[s]),
         .qy_i   (dqy[s]),
         .valid_o(dv[s + 1]),
         .tag_o  (dtag[s + 1]),
         .den_o  (dden[s + 1]),
         .numx_o (dnx[s + 1]),
         .numy_o (dny[s + 1]),
         .remx_o (drx[s + 1]),
         .remy_o (dry[s + 1]),
         .qx_o   (dqx[s + 1]),
         .qy_o   (dqy[s + 1])
      );
   end

   // Final stage: place the point on the circle or pass the moved point.
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   tag_type            ft;
   logic signed [33:0] ox, oy;

   always_comb begin
      ft = dtag[QUO_BITS];
      if (dden[QUO_BITS] == 32'd0) begin
         ox = 34'sd0;
         oy = 34'sd0;
      end else begin
         ox = 34'(dqx[QUO_BITS]);
         oy = 34'(dqy[QUO_BITS]);
      end
      if (ft.neg_x) begin
         ox = -ox;
      end
      if (ft.neg_y) begin
         oy = -oy;
      end
      rsp_in.was_clamped = ft.clamped;
      rsp_in.last_out    = ft.last;
      if (ft.clamped) begin
         rsp_in.new_x = sat32(65'(cx_ff) + 65'(ox));
         rsp_in.new_y = sat32(65'(cy_ff) + 65'(oy));
      end else begin
         rsp_in.new_x = ft.mx;
         rsp_in.new_y = ft.my;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // The square root of a 63-bit value never needs more than 32 bits.
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      sv[ROOT_BITS] |-> (sroot[ROOT_BITS][63:32] == 32'd0))
      else $error("square root overflowed 32 bits");

   // A projected offset never exceeds the radius.
   a_offset_le_radius: assert property (@(posedge clock) disable iff (reset)
      (dv[QUO_BITS] && dtag[QUO_BITS].clamped && dden[QUO_BITS] != 32'd0)
      |-> (dqx[QUO_BITS] <= rad_ff && dqy[QUO_BITS] <= rad_ff))
      else $error("projected offset beyond radius");

   // An item leaving the divider reaches the response register.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (en && dv[QUO_BITS]) |=> rsp_valid)
      else $error("item lost at the response register");

   // A clamped point keeps its clamp flag as it enters the square root chain.
   a_clamp_kept: assert property (@(posedge clock) disable iff (reset)
      (en && v5_ff && tag5_ff.clamped) |=> stag[1].clamped)
      else $error("clamp flag lost entering the square root chain");
`endif

endmodule

// ===== tb/tb_disk_projected_gradient_step_unit.sv =====
module tb_disk_projected_gradient_step_unit;
   import dpgs_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_idx = CSR_STEP;
   logic [31:0]       csr_wdata = '0;

   // Shadow copy of the block's registers.
   logic signed [31:0] step_reg;
   logic signed [31:0] cx_reg;
   logic signed [31:0] cy_reg;
   logic [30:0]        radius_reg;

   rsp_type expected_points[$];
   int      error_count = 0;
   int      sent_count = 0;
   int      clamp_count = 0;
   int      checked_count = 0;
   int      stall_left = 0;
   bit      no_idle = 1'b0;

   disk_projected_gradient_step_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Floor of the square root of a 64-bit value, one bit pair per step.
   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Gradient step of one coordinate with round half up, then saturation.
   function automatic logic signed [31:0] step_coord(input logic signed [31:0] pos,
                                                     input logic signed [31:0] grad);
      logic signed [65:0] prod;
      logic signed [65:0] delta;
      prod = 66'(grad) * 66'(step_reg);
      delta = (prod + 66'sd32768) >>> 16;
      return clip32(66'(pos) + delta);
   endfunction

   // Expected updated point for one request under the current registers.
   function automatic rsp_type project_point(input req_type r);
      rsp_type            o;
      logic signed [31:0] mx, my;
      logic signed [33:0] dx, dy;
      logic [63:0]        ux, uy, rr, n, ox, oy;
      logic               clamped;
      mx = step_coord(r.pos_x, r.grad_x);
      my = step_coord(r.pos_y, r.grad_y);
      dx = 34'(mx) - 34'(cx_reg);
      dy = 34'(my) - 34'(cy_reg);
      ux = dx < 0 ? 64'(-dx) : 64'(dx);
      uy = dy < 0 ? 64'(-dy) : 64'(dy);
      rr = 64'(radius_reg);
      if (ux >= 64'h80000000 || uy >= 64'h80000000) begin
         clamped = 1'b1;
      end else begin
         clamped = ux * ux + uy * uy > rr * rr;
      end
      o.new_x = mx;
      o.new_y = my;
      if (clamped) begin
         while (ux >= 64'h80000000 || uy >= 64'h80000000) begin
            ux = ux >> 1;
            uy = uy >> 1;
         end
         n = floor_root(ux * ux + uy * uy);
         ox = 0;
         oy = 0;
         if (n != 0) begin
            ox = (ux * rr + n / 2) / n;
            oy = (uy * rr + n / 2) / n;
         end
         o.new_x = clip32(66'(cx_reg) + (dx < 0 ? -66'(ox) : 66'(ox)));
         o.new_y = clip32(66'(cy_reg) + (dy < 0 ? -66'(oy) : 66'(oy)));
      end
      o.was_clamped = clamped;
      o.last_out = r.last_point;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 11);
   endfunction

   // Send one request after a random gap and predict its result.
   task automatic send_point(input req_type r);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      expected_points.push_back(project_point(r));
      sent_count++;
   endtask

   // Drop valid and wait until every predicted point has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Register write while the pipeline is empty.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEP:     step_reg = value;
         CSR_CENTER_X: cx_reg = value;
         CSR_CENTER_Y: cy_reg = value;
         CSR_RADIUS:   radius_reg = value[30:0];
      endcase
   endtask

   // Coordinate values: wide random, small, or extreme.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h80000000 | ($urandom_range(0, 3));
         2: return 32'h7fffffff - $urandom_range(0, 3);
         3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
         default: return $urandom_range(0, 32'h7ffff) - 32'h40000;
      endcase
   endfunction

   function automatic req_type make_point(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] gx, input logic [31:0] gy,
                                          input logic lastp);
      req_type r;
      r.pos_x = px;
      r.pos_y = py;
      r.grad_x = gx;
      r.grad_y = gy;
      r.last_point = lastp;
      return r;
   endfunction

   // Random point, often placed right around the current circle.
   function automatic req_type random_point();
      logic [31:0] px, py;
      px = pick_value();
      py = pick_value();
      if ($urandom_range(0, 3) == 0) begin
         px = cx_reg + radius_reg + $urandom_range(0, 2) - 1;
         py = cy_reg;
      end
      return make_point(px, py, pick_value(),
                        $urandom_range(0, 2) == 0 ? 32'd0 : pick_value(),
                        $urandom_range(0, 1));
   endfunction

   // Checking of every accepted response against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.new_x !== want.new_x)
               report_mismatch("new_x", rsp_data.new_x, want.new_x);
            if (rsp_data.new_y !== want.new_y)
               report_mismatch("new_y", rsp_data.new_y, want.new_y);
            if (rsp_data.was_clamped !== want.was_clamped)
               report_mismatch("was_clamped", rsp_data.was_clamped, want.was_clamped);
            if (rsp_data.last_out !== want.last_out)
               report_mismatch("last_out", rsp_data.last_out, want.last_out);
            clamp_count += want.was_clamped;
         end
         checked_count++;
         stall_left = draw_gap();
      end
   end

   // Response side back-pressure, a fresh count per response.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_directed();
      send_point(make_point(0, 0, 0, 0, 1'b0));
      send_point(make_point(32'h10000, 0, 0, 0, 1'b1));
      send_point(make_point(32'h10001, 0, 0, 0, 1'b0));
      send_point(make_point(32'h8000, 32'h8000, 32'h8000, 32'h8000, 1'b0));
      send_point(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
      send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
      send_point(make_point(32'h7fffffff, 32'h80000000, 0, 0, 1'b1));
      send_point(make_point(0, 0, 32'h1, 32'hffffffff, 1'b0));
      send_point(make_point(0, 0, 32'h8000, 32'hffff8000, 1'b0));
      send_point(make_point(32'hfffe0000, 32'h00030000, 32'h1, 32'h0, 1'b1));
      // Zero radius pulls every point but the center itself onto the center.
      write_reg(CSR_RADIUS, 32'h0);
      send_point(make_point(0, 0, 0, 0, 1'b0));
      send_point(make_point(1, 0, 0, 0, 1'b1));
      send_point(make_point(32'h80000000, 32'h7fffffff, 0, 0, 1'b0));
      // Center at an extreme corner makes the offsets wider than 32 bits.
      write_reg(CSR_CENTER_X, 32'h80000000);
      write_reg(CSR_CENTER_Y, 32'h7fffffff);
      write_reg(CSR_RADIUS, 32'hffffffff);
      send_point(make_point(32'h7fffffff, 32'h80000000, 0, 0, 1'b0));
      send_point(make_point(0, 0, 0, 0, 1'b1));
      send_point(make_point(32'h80000000, 32'h7fffffff, 0, 0, 1'b0));
      write_reg(CSR_STEP, 32'h80000000);
      send_point(make_point(0, 0, 32'h80000000, 32'h7fffffff, 1'b1));
      send_point(make_point(0, 0, 32'h1, 32'hffffffff, 1'b0));
   endtask

   // Sweep of register settings, extremes among them, each with random points.
   task automatic test_register_sweep();
      logic [31:0] steps[5] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h10000, 32'hffff0000};
      logic [31:0] radii[4] = '{32'h0, 32'h7fffffff, 32'h10000, 32'h80001234};
      for (int k = 0; k < 8; k++) begin
         write_reg(CSR_STEP, k < 5 ? steps[k] : $urandom_range(0, 32'h3ffff) - 32'h20000);
         write_reg(CSR_CENTER_X, k < 2 ? 32'h0 : pick_value());
         write_reg(CSR_CENTER_Y, k < 2 ? 32'h0 : pick_value());
         write_reg(CSR_RADIUS, k < 4 ? radii[k] : $urandom());
         no_idle = (k == 3);
         repeat (40) send_point(random_point());
      end
      no_idle = 1'b0;
   endtask

   // Long random run under a moderate setting.
   task automatic test_random_stream();
      write_reg(CSR_STEP, 32'h4000 + $urandom_range(0, 32'h10000));
      write_reg(CSR_CENTER_X, $urandom_range(0, 32'h40000) - 32'h20000);
      write_reg(CSR_CENTER_Y, $urandom_range(0, 32'h40000) - 32'h20000);
      write_reg(CSR_RADIUS, 32'h8000 + $urandom_range(0, 32'h40000));
      for (int i = 0; i < 510; i++) begin
         no_idle = (i >= 200 && i < 280);
         send_point(random_point());
         // The sender holds off once until the pipeline has emptied.
         if (i == 300) drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      step_reg = 32'sh10000;
      cx_reg = 0;
      cy_reg = 0;
      radius_reg = 31'h10000;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_sweep();
      test_random_stream();
      drain();
      $display("Sent %0d points, %0d responses checked, %0d of them clamped,",
               sent_count, checked_count, clamp_count);
      $display("across register sweeps with extreme step, center and radius.");
      if (error_count == 0) begin
         $display("tb_disk_projected_gradient_step_unit: done, clean");
      end else begin
         $display("tb_disk_projected_gradient_step_unit: done, errors");
      end
      $finish;
   end

   initial begin
      #600000;
      $display("timeout");
      $display("tb_disk_projected_gradient_step_unit: done, errors");
      $finish;
   end

endmodule

// ===== disk_projected_gradient_step_unit.f =====
rtl/core/dpgs_pkg.sv
rtl/core/dpgs_sqrt_cell.sv
rtl/core/dpgs_div_cell.sv
rtl/core/disk_projected_gradient_step_unit.sv
tb/tb_disk_projected_gradient_step_unit.sv
